FILE: rtl/core/ipcsum_pkg.sv
// Package for the IPv4 / TCP / UDP checksum engine.
// Holds payload and queue types, command and protocol codes, and the
// ones-complement add used by the execution stage. No dependencies.
package ipcsum_pkg;

   localparam int HEADER_WORDS_DEFAULT = 10;
   localparam int QUEUE_DEPTH          = 2;
   localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_HEADER = 2'd1;
   localparam logic [1:0] CMD_XPORT  = 2'd2;

   localparam logic [1:0] BC_NONE = 2'd0;
   localparam logic [1:0] BC_ODD  = 2'd1;
   localparam logic [1:0] BC_FULL = 2'd2;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam int HDR_PROTO_WORD = 4;
   localparam int HDR_CSUM_SLOT  = 5;
   localparam int HDR_ADDR_FIRST = 6;
   localparam int HDR_ADDR_LAST  = 9;

   localparam int         XPORT_IDX_W   = 4;
   localparam logic [3:0] XPORT_IDX_MAX = 4'd9;
   localparam logic [3:0] TCP_CSUM_SLOT = 4'd8;
   localparam logic [3:0] UDP_CSUM_SLOT = 4'd3;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_XPORT  = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] data_word;
      logic [1:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] checksum_value;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_HEADER = 2'd1,
      OP_XPORT  = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] value;
      logic [1:0]  bytes;
      logic        last;
   } work_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   empty;
      logic                   full;
   } qstat_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

FILE: rtl/core/ipcsum_front.sv
// Front end: accepts request transfers and classifies them into work items.
// Depends on ipcsum_pkg.
module ipcsum_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipcsum_pkg::req_type  req_payload,
   input  ipcsum_pkg::qstat_type q_stat,
   output logic                 push,
   output ipcsum_pkg::work_type push_item
);
   import ipcsum_pkg::*;

   logic known;

   assign req_ready = !q_stat.full;

   always_comb begin
      known          = 1'b1;
      push_item.op   = OP_START;
      push_item.last = req_payload.last;
      unique case (req_payload.command)
         CMD_START:  push_item.op = OP_START;
         CMD_HEADER: push_item.op = OP_HEADER;
         CMD_XPORT:  push_item.op = OP_XPORT;
         default:    known = 1'b0;
      endcase
      if (req_payload.command == CMD_XPORT) begin
         unique case (req_payload.byte_count)
            BC_NONE: begin
               push_item.value = 16'd0;
               push_item.bytes = 2'd0;
            end
            BC_ODD: begin
               push_item.value = {req_payload.data_word[15:8], 8'd0};
               push_item.bytes = 2'd1;
            end
            default: begin
               push_item.value = req_payload.data_word;
               push_item.bytes = 2'd2;
            end
         endcase
      end else begin
         push_item.value = req_payload.data_word;
         push_item.bytes = 2'd0;
      end
   end

   // drop unknown commands
   assign push = req_valid && req_ready && known;

endmodule

FILE: rtl/core/ipcsum_queue.sv
// Two-entry work queue between the front end and the execution stage.
// Depends on ipcsum_pkg.
module ipcsum_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ipcsum_pkg::work_type  push_item,
   input  logic                  pop,
   output ipcsum_pkg::work_type  head_item,
   output ipcsum_pkg::qstat_type q_stat
);
   import ipcsum_pkg::*;

   work_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/core/ipcsum_back.sv
// Execution stage: header and transport ones-complement sums, pseudo-header,
// byte counting and the result register. Depends on ipcsum_pkg.
module ipcsum_back #(
   parameter int HEADER_WORDS = ipcsum_pkg::HEADER_WORDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ipcsum_pkg::work_type  head_item,
   input  ipcsum_pkg::qstat_type q_stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ipcsum_pkg::rsp_type   rsp_payload
);
   import ipcsum_pkg::*;

   localparam int HdrIdxW = $clog2(HEADER_WORDS + 1);

   logic [15:0]            hsum_ff, hsum_in;
   logic [15:0]            tsum_ff, tsum_in;
   logic [HdrIdxW-1:0]     hidx_ff, hidx_in;
   logic [XPORT_IDX_W-1:0] xidx_ff, xidx_in;
   logic [15:0]            total_ff, total_in;
   logic [7:0]             proto_ff, proto_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_payload_ff, rsp_payload_in;

   logic        load;
   rsp_type     load_payload;
   logic        is_tcp, is_udp;
   logic [15:0] xval;
   logic [16:0] total_sum;
   logic [15:0] pseudo_sum;
   logic [15:0] final_sum;

   assign pop    = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
   assign is_tcp = (proto_ff == PROTO_TCP);
   assign is_udp = (proto_ff == PROTO_UDP);

   always_comb begin
      hsum_in      = hsum_ff;
      tsum_in      = tsum_ff;
      hidx_in      = hidx_ff;
      xidx_in      = xidx_ff;
      total_in     = total_ff;
      proto_in     = proto_ff;
      load         = 1'b0;
      load_payload = rsp_payload_ff;
      xval         = head_item.value;
      if ((is_tcp && xidx_ff == TCP_CSUM_SLOT) || (is_udp && xidx_ff == UDP_CSUM_SLOT)) begin
         xval = 16'd0;
      end
      total_sum  = {1'b0, total_ff} + {15'd0, head_item.bytes};
      pseudo_sum = 16'd0;
      final_sum  = 16'd0;
      if (pop) begin
         unique case (head_item.op)
            OP_START: begin
               hsum_in  = '0;
               tsum_in  = '0;
               hidx_in  = '0;
               xidx_in  = '0;
               total_in = '0;
               proto_in = '0;
            end
            OP_HEADER: begin
               if (hidx_ff < HdrIdxW'(HEADER_WORDS)) begin
                  if (hidx_ff != HdrIdxW'(HDR_CSUM_SLOT)) begin
                     hsum_in = oc_add(hsum_ff, head_item.value);
                  end
                  if (hidx_ff == HdrIdxW'(HDR_PROTO_WORD)) begin
                     proto_in = head_item.value[7:0];
                  end
                  if (hidx_ff >= HdrIdxW'(HDR_ADDR_FIRST) &&
                      hidx_ff <= HdrIdxW'(HDR_ADDR_LAST)) begin
                     tsum_in = oc_add(tsum_ff, head_item.value);
                  end
                  hidx_in = hidx_ff + 1'b1;
                  if (hidx_in == HdrIdxW'(HEADER_WORDS)) begin
                     load                        = 1'b1;
                     load_payload.result_kind    = KIND_HEADER;
                     load_payload.checksum_value = ~hsum_in;
                  end
               end
            end
            OP_XPORT: begin
               tsum_in = oc_add(tsum_ff, xval);
               if (xidx_ff != XPORT_IDX_MAX) begin
                  xidx_in = xidx_ff + 1'b1;
               end
               total_in   = total_sum[16] ? 16'hFFFF : total_sum[15:0];
               pseudo_sum = oc_add(tsum_in, {8'd0, proto_ff});
               final_sum  = ~oc_add(pseudo_sum, total_in);
               if (head_item.last && (is_tcp || is_udp)) begin
                  load                        = 1'b1;
                  load_payload.result_kind    = KIND_XPORT;
                  load_payload.checksum_value =
                     (is_udp && final_sum == 16'd0) ? 16'hFFFF : final_sum;
               end
            end
            default: ;
         endcase
      end
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = load_payload;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff      <= '0;
         tsum_ff      <= '0;
         hidx_ff      <= '0;
         xidx_ff      <= '0;
         total_ff     <= '0;
         proto_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hsum_ff      <= hsum_in;
         tsum_ff      <= tsum_in;
         hidx_ff      <= hidx_in;
         xidx_ff      <= xidx_in;
         total_ff     <= total_in;
         proto_ff     <= proto_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/core/ipv4_tcp_udp_checksum_engine_unit.sv
// IPv4 header and TCP/UDP checksum engine. One request word is taken per cycle
// while the work queue is not full. A taken word is written to the front-end
// queue at the accepting edge; the execution stage then pops it and loads the
// result register, where a checksum, when one is due, is held valid.
// Words flow back to back as long as results are taken. A stalled result holds
// the queue, the two-entry queue fills, and the request side then stalls.
// Depends on ipcsum_pkg, ipcsum_front, ipcsum_queue and ipcsum_back.
module ipv4_tcp_udp_checksum_engine_unit #(
   parameter int HEADER_WORDS = ipcsum_pkg::HEADER_WORDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ipcsum_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ipcsum_pkg::rsp_type rsp_payload
);
   import ipcsum_pkg::*;

   qstat_type q_stat;
   work_type  push_item;
   work_type  head_item;
   logic      push;
   logic      pop;

   ipcsum_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_item   (push_item)
   );

   ipcsum_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   ipcsum_back #(
      .HEADER_WORDS (HEADER_WORDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty work queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> q_stat.count ==
         $past(q_stat.count) + QUEUE_CNT_W'($past(push)) - QUEUE_CNT_W'($past(pop)))
      else $error("work queue count out of step with transfers");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.op == OP_START) |=> !$rose(rsp_valid))
      else $error("start item produced a result");

endmodule
